/* sv/blg_pkg.sv */
// Package for the battery LED bar gauge: register map, reset values and the
// structs shared by the step logic and the top level. No dependencies.
package blg_pkg;

    localparam int MV_W    = 14;
    localparam int CNT_W   = 8;
    localparam int LED_N   = 4;
    localparam int IDX_W   = 3;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_LEVEL1          = 3'd0;
    localparam logic [IDX_W-1:0] REG_LEVEL2          = 3'd1;
    localparam logic [IDX_W-1:0] REG_LEVEL3          = 3'd2;
    localparam logic [IDX_W-1:0] REG_LEVEL4          = 3'd3;
    localparam logic [IDX_W-1:0] REG_CEILING         = 3'd4;
    localparam logic [IDX_W-1:0] REG_DISCHARGE_FLOOR = 3'd5;
    localparam logic [IDX_W-1:0] REG_CHARGE_FLOOR    = 3'd6;
    localparam logic [IDX_W-1:0] REG_BLINK_TICKS     = 3'd7;

    // Reset values
    localparam logic [MV_W-1:0]  LEVEL1_RST          = 14'd6200;
    localparam logic [MV_W-1:0]  LEVEL2_RST          = 14'd6600;
    localparam logic [MV_W-1:0]  LEVEL3_RST          = 14'd7200;
    localparam logic [MV_W-1:0]  LEVEL4_RST          = 14'd7800;
    localparam logic [MV_W-1:0]  CEILING_RST         = 14'd15000;
    localparam logic [MV_W-1:0]  DISCHARGE_FLOOR_RST = 14'd5000;
    localparam logic [MV_W-1:0]  CHARGE_FLOOR_RST    = 14'd3000;
    localparam logic [CNT_W-1:0] BLINK_TICKS_RST     = 8'd5;
    localparam logic [MV_W-1:0]  TRACKED_RST         = 14'd12601;

    // Bar patterns
    localparam logic [LED_N-1:0] BAR_NONE  = 4'b0000;
    localparam logic [LED_N-1:0] BAR_ONE   = 4'b0001;
    localparam logic [LED_N-1:0] BAR_TWO   = 4'b0011;
    localparam logic [LED_N-1:0] BAR_THREE = 4'b0111;
    localparam logic [LED_N-1:0] BAR_FULL  = 4'b1111;

    typedef struct packed {
        logic [MV_W-1:0]  level1_mv;
        logic [MV_W-1:0]  level2_mv;
        logic [MV_W-1:0]  level3_mv;
        logic [MV_W-1:0]  level4_mv;
        logic [MV_W-1:0]  ceiling_mv;
        logic [MV_W-1:0]  discharge_floor_mv;
        logic [MV_W-1:0]  charge_floor_mv;
        logic [CNT_W-1:0] blink_ticks;
    } cfg_t;

    typedef struct packed {
        logic [MV_W-1:0]  tracked_mv;
        logic [CNT_W-1:0] blink_count;
        logic [LED_N-1:0] led_bits;   // bit0 = LED1
    } gauge_state_t;

endpackage

/* sv/blg_step.sv */
// Next-state logic of the gauge for one tick: tracking, level select, blink.
// Depends on blg_pkg.
module blg_step
(
    input  blg_pkg::cfg_t            cfg,
    input  blg_pkg::gauge_state_t    st,
    input  logic                     discharging,
    input  logic                     charger_present,
    input  logic [blg_pkg::MV_W-1:0] battery_mv,
    input  logic                     charge_done,
    output blg_pkg::gauge_state_t    nxt,
    output logic                     clear_req
);

    logic [blg_pkg::MV_W-1:0]  trk_dis;
    logic [blg_pkg::MV_W-1:0]  trk_chg;
    logic [blg_pkg::CNT_W-1:0] cnt_inc;
    logic                      cnt_hit;
    logic [blg_pkg::LED_N-1:0] lit_mask;
    logic [1:0]                blink_pos;
    logic                      chg_level;
    logic [blg_pkg::LED_N-1:0] pos_bit;
    logic [blg_pkg::LED_N-1:0] keep_bit;

    // Tracked voltage candidates: minimum on discharge, maximum on charge
    assign trk_dis = (battery_mv > cfg.discharge_floor_mv && battery_mv < st.tracked_mv)
                     ? battery_mv : st.tracked_mv;
    assign trk_chg = (battery_mv > cfg.charge_floor_mv && battery_mv > st.tracked_mv)
                     ? battery_mv : st.tracked_mv;

    assign cnt_inc = st.blink_count + 8'd1;
    assign cnt_hit = (cnt_inc >= cfg.blink_ticks);

    // Charge mode level: lit bar below and the blinking LED position
    always_comb
    begin
        chg_level = 1'b1;
        lit_mask  = blg_pkg::BAR_NONE;
        blink_pos = 2'd0;
        if (trk_chg < cfg.level2_mv)
        begin
            lit_mask  = blg_pkg::BAR_NONE;
            blink_pos = 2'd0;
        end
        else if (trk_chg < cfg.level3_mv)
        begin
            lit_mask  = blg_pkg::BAR_ONE;
            blink_pos = 2'd1;
        end
        else if (trk_chg < cfg.level4_mv)
        begin
            lit_mask  = blg_pkg::BAR_TWO;
            blink_pos = 2'd2;
        end
        else if (trk_chg < cfg.ceiling_mv)
        begin
            lit_mask  = blg_pkg::BAR_THREE;
            blink_pos = 2'd3;
        end
        else
        begin
            chg_level = 1'b0;
        end
    end

    // Blinking LED keeps its state, toggles when the count reaches the period
    assign pos_bit  = blg_pkg::BAR_ONE << blink_pos;
    assign keep_bit = cnt_hit ? ((st.led_bits & pos_bit) ^ pos_bit) : (st.led_bits & pos_bit);

    always_comb
    begin
        nxt       = st;
        clear_req = 1'b0;
        if (discharging && !charger_present)
        begin
            nxt.tracked_mv = trk_dis;
            if (trk_dis < cfg.level1_mv)
            begin
                // low: LED1 blinks alone
                nxt.blink_count = cnt_hit ? '0 : cnt_inc;
                nxt.led_bits    = {3'b000, st.led_bits[0] ^ cnt_hit};
            end
            else if (trk_dis < cfg.level2_mv)
                nxt.led_bits = blg_pkg::BAR_ONE;
            else if (trk_dis < cfg.level3_mv)
                nxt.led_bits = blg_pkg::BAR_TWO;
            else if (trk_dis < cfg.level4_mv)
                nxt.led_bits = blg_pkg::BAR_THREE;
            else if (trk_dis < cfg.ceiling_mv)
                nxt.led_bits = blg_pkg::BAR_FULL;
        end
        else if (charger_present)
        begin
            nxt.blink_count = cnt_inc;
            if (charge_done)
            begin
                clear_req       = 1'b1;
                nxt.blink_count = '0;
                nxt.led_bits    = blg_pkg::BAR_FULL;
            end
            else
            begin
                nxt.tracked_mv = trk_chg;
                if (chg_level)
                begin
                    nxt.led_bits = lit_mask | keep_bit;
                    if (cnt_hit)
                        nxt.blink_count = '0;
                end
            end
        end
        else
        begin
            nxt.led_bits = blg_pkg::BAR_NONE;
        end
    end

endmodule

/* sv/battery_led_bar_gauge.sv */
// Top level of the battery LED bar gauge: configuration registers, gauge
// state, and the result register. Depends on blg_pkg and blg_step.
//
//  channel   handshake              payload
//  -------   ---------------------  -------------------------------------------
//  input     in_valid / in_ready    discharging, charger_present, battery_mv,
//                                   charge_done
//  result    out_valid / out_ready  led_one..led_four, clear_done_request
//  config    cfg_write (no wait)    cfg_index, cfg_data
//
// One item per cycle while results are taken: the whole tick is evaluated in
// the cycle it is accepted and its result is in the result register on the
// next cycle. in_ready is high whenever the result register is empty or being
// taken, so a stalled result only holds off the next item. Reset restores all
// configuration registers to their defaults, puts the gauge state at its start
// values and empties the result register.
module battery_led_bar_gauge
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_write,
    input  logic [blg_pkg::IDX_W-1:0] cfg_index,
    input  logic [blg_pkg::MV_W-1:0]  cfg_data,
    // input items
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      discharging,
    input  logic                      charger_present,
    input  logic [blg_pkg::MV_W-1:0]  battery_mv,
    input  logic                      charge_done,
    // result items
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      led_one,
    output logic                      led_two,
    output logic                      led_three,
    output logic                      led_four,
    output logic                      clear_done_request
);

    blg_pkg::cfg_t         cfg_reg;
    blg_pkg::gauge_state_t state_reg;
    blg_pkg::gauge_state_t state_next;
    logic                  clear_next;
    logic                  out_valid_reg;
    logic [blg_pkg::LED_N-1:0] led_reg;
    logic                  clear_reg;
    logic                  in_accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level1_mv          <= blg_pkg::LEVEL1_RST;
            cfg_reg.level2_mv          <= blg_pkg::LEVEL2_RST;
            cfg_reg.level3_mv          <= blg_pkg::LEVEL3_RST;
            cfg_reg.level4_mv          <= blg_pkg::LEVEL4_RST;
            cfg_reg.ceiling_mv         <= blg_pkg::CEILING_RST;
            cfg_reg.discharge_floor_mv <= blg_pkg::DISCHARGE_FLOOR_RST;
            cfg_reg.charge_floor_mv    <= blg_pkg::CHARGE_FLOOR_RST;
            cfg_reg.blink_ticks        <= blg_pkg::BLINK_TICKS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                blg_pkg::REG_LEVEL1:          cfg_reg.level1_mv          <= cfg_data;
                blg_pkg::REG_LEVEL2:          cfg_reg.level2_mv          <= cfg_data;
                blg_pkg::REG_LEVEL3:          cfg_reg.level3_mv          <= cfg_data;
                blg_pkg::REG_LEVEL4:          cfg_reg.level4_mv          <= cfg_data;
                blg_pkg::REG_CEILING:         cfg_reg.ceiling_mv         <= cfg_data;
                blg_pkg::REG_DISCHARGE_FLOOR: cfg_reg.discharge_floor_mv <= cfg_data;
                blg_pkg::REG_CHARGE_FLOOR:    cfg_reg.charge_floor_mv    <= cfg_data;
                blg_pkg::REG_BLINK_TICKS:
                    cfg_reg.blink_ticks <= cfg_data[blg_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Tick evaluation
    blg_step u_step
    (
        .cfg             (cfg_reg),
        .st              (state_reg),
        .discharging     (discharging),
        .charger_present (charger_present),
        .battery_mv      (battery_mv),
        .charge_done     (charge_done),
        .nxt             (state_next),
        .clear_req       (clear_next)
    );

    // Gauge state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.tracked_mv  <= blg_pkg::TRACKED_RST;
            state_reg.blink_count <= '0;
            state_reg.led_bits    <= blg_pkg::BAR_NONE;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            led_reg   <= state_next.led_bits;
            clear_reg <= clear_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign led_one            = led_reg[0];
    assign led_two            = led_reg[1];
    assign led_three          = led_reg[2];
    assign led_four           = led_reg[3];
    assign clear_done_request = clear_reg;

`ifndef ASSERT_OFF
    // A clear request always comes with the full bar
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && clear_reg |-> led_reg == blg_pkg::BAR_FULL)
        else $error("clear request without full bar");

    // Charge done clears the blink counter
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && charger_present && charge_done |=> state_reg.blink_count == '0)
        else $error("blink count not cleared on charge done");

    // Discharge tracking never raises the tracked voltage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && discharging && !charger_present
        |=> state_reg.tracked_mv <= $past(state_reg.tracked_mv))
        else $error("tracked voltage rose on discharge");

    // Result register tracks the state LEDs after every item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> led_reg == state_reg.led_bits)
        else $error("result LEDs differ from gauge state");
`endif

endmodule
